>>> rtl/yre_pkg.sv
package yre_pkg;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ALPHA = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_THRESH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRONT_THRESH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_THRESH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_INTERVAL = 3'd4;

  // Action codes carried on s_tuser.
  typedef enum logic [1:0] {
    ACT_UPDATE     = 2'd0,
    ACT_TAKE_DELTA = 2'd1,
    ACT_ZERO_REF   = 2'd2,
    ACT_RESYNC_REF = 2'd3
  } action_t;

  // Number of restoring divide steps: one per bit of the scaled delta.
  localparam int DIV_STEPS = 35;
  localparam int DIV_CNT_W = 6;

  // Configuration register file contents.
  typedef struct packed {
    logic [16:0] filter_alpha;
    logic [12:0] left_threshold_mm;
    logic [12:0] front_threshold_mm;
    logic [12:0] right_threshold_mm;
    logic [15:0] min_interval_us;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic mac;
    logic sum;
    logic out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic upd_req;
  } status_t;

endpackage

>>> rtl/yre_regs.sv
module yre_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [yre_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [yre_pkg::CFG_DATA_W-1:0]  cfg_data,
  output yre_pkg::cfg_t                  cfg
);
  import yre_pkg::*;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_alpha       <= 17'd13107;
      cfg.left_threshold_mm  <= 13'd100;
      cfg.front_threshold_mm <= 13'd100;
      cfg.right_threshold_mm <= 13'd100;
      cfg.min_interval_us    <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILTER_ALPHA: cfg.filter_alpha       <= cfg_data;
        REG_LEFT_THRESH:  cfg.left_threshold_mm  <= cfg_data[12:0];
        REG_FRONT_THRESH: cfg.front_threshold_mm <= cfg_data[12:0];
        REG_RIGHT_THRESH: cfg.right_threshold_mm <= cfg_data[12:0];
        REG_MIN_INTERVAL: cfg.min_interval_us    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/yre_ctrl.sv
module yre_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  yre_pkg::status_t  status,
  output yre_pkg::cmd_t     cmd
);
  import yre_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_DIV  = 6'b000100,
    S_MAC  = 6'b001000,
    S_SUM  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 out_free;
  logic                 accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = status.upd_req ? S_PREP : S_DONE;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and divide step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_PREP) begin
        cnt <= '0;
      end else if (state == S_DIV) begin
        cnt <= cnt + DIV_CNT_W'(1);
      end
    end
  end

  // Output valid: set when a result is loaded, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // The divide never runs past its last step.
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt < DIV_CNT_W'(DIV_STEPS)))
    else $error("divide counter ran past its last step");

  // An update request goes through the divider; others go straight to output.
  a_upd_path: assert property (@(posedge clk) disable iff (rst)
    (accept && status.upd_req) |=> (state == S_PREP))
    else $error("update request did not start the divider");

  a_skip_path: assert property (@(posedge clk) disable iff (rst)
    (accept && !status.upd_req) |=> (state == S_DONE))
    else $error("non-update request did not go to output");

  // A result is never loaded over one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending result");

  // The filter update is always followed by the output step.
  a_sum_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) |=> (state == S_DONE))
    else $error("filter update not followed by output");

endmodule

>>> rtl/yre_dp.sv
module yre_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  yre_pkg::cfg_t                  cfg,
  input  yre_pkg::cmd_t                  cmd,
  output yre_pkg::status_t               status,
  input  logic [yre_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [yre_pkg::IN_USER_W-1:0]  s_tuser,
  output logic [yre_pkg::OUT_DATA_W-1:0] m_tdata
);
  import yre_pkg::*;

  localparam logic [27:0] RATE_LIMIT = 28'd180000000;
  localparam logic [16:0] ALPHA_ONE  = 17'd65536;
  localparam logic [34:0] RATE_SCALE = 35'd1000000;

  // Wrap a yaw difference once into the half-turn range.
  function automatic logic signed [17:0] wrap_delta(input logic signed [17:0] d);
    logic signed [17:0] r;
    r = d;
    if (d > 18'sd18000) begin
      r = d - 18'sd36000;
    end else if (d < -18'sd18000) begin
      r = d + 18'sd36000;
    end
    return r;
  endfunction

  // Input fields.
  logic signed [15:0] in_yaw;
  logic [19:0]        in_elapsed;
  logic [12:0]        in_left;
  logic [12:0]        in_front;
  logic [12:0]        in_right;
  logic [1:0]         in_action;

  assign in_yaw     = s_tdata[15:0];
  assign in_elapsed = s_tdata[35:16];
  assign in_left    = s_tdata[48:36];
  assign in_front   = s_tdata[61:49];
  assign in_right   = s_tdata[74:62];
  assign in_action  = s_tuser;

  // Stored state.
  logic signed [15:0] prev_yaw;
  logic signed [15:0] ref_yaw;
  logic signed [28:0] filt;

  // Per-item registers.
  logic signed [15:0] yaw_q;
  logic [19:0]        den;
  logic [2:0]         flags_q;
  logic [15:0]        delta_q;
  logic               upd_q;
  logic               neg_q;
  logic [14:0]        mag_q;
  logic [19:0]        rem;
  logic [34:0]        quo;
  logic signed [46:0] p_new;
  logic signed [46:0] p_old;

  // Load-time combinational values.
  logic signed [17:0] d_rate;
  logic signed [17:0] d_take;
  logic signed [17:0] d_abs;

  assign status.upd_req = (in_action == ACT_UPDATE) && (in_elapsed != 20'd0) &&
                          (in_elapsed >= {4'd0, cfg.min_interval_us});

  assign d_rate = wrap_delta(18'(in_yaw) - 18'(prev_yaw));
  assign d_take = wrap_delta(18'(in_yaw) - 18'(ref_yaw));
  assign d_abs  = d_rate[17] ? -d_rate : d_rate;

  // Divide step: shift in the next dividend bit and try subtracting.
  logic [20:0] rem_sh;
  logic [21:0] diff;

  assign rem_sh = {rem, quo[34]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};

  // Saturated signed raw rate and clamped alpha.
  logic [27:0]        sat_mag;
  logic signed [28:0] raw;
  logic [16:0]        alpha_sat;
  logic signed [17:0] a_new;
  logic signed [17:0] a_old;

  assign sat_mag   = (quo > {7'd0, RATE_LIMIT}) ? RATE_LIMIT : quo[27:0];
  assign raw       = neg_q ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});
  assign alpha_sat = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
  assign a_new     = $signed({1'b0, alpha_sat});
  assign a_old     = $signed({1'b0, ALPHA_ONE}) - a_new;

  // Blended sum; the floor shift by 16 is a bit select.
  logic signed [47:0] blend;

  assign blend = 48'(p_new) + 48'(p_old);

  // Stored state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_yaw <= '0;
      ref_yaw  <= '0;
      filt     <= '0;
    end else begin
      if (cmd.load) begin
        case (in_action)
          ACT_TAKE_DELTA: ref_yaw <= in_yaw;
          ACT_ZERO_REF:   ref_yaw <= '0;
          ACT_RESYNC_REF: ref_yaw <= in_yaw;
          default: begin
          end
        endcase
      end
      if (cmd.sum) begin
        filt     <= blend[44:16];
        prev_yaw <= yaw_q;
      end
    end
  end

  // Item capture, divide and multiply pipeline.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      yaw_q   <= in_yaw;
      den     <= in_elapsed;
      flags_q <= {in_right < cfg.right_threshold_mm,
                  in_front < cfg.front_threshold_mm,
                  in_left  < cfg.left_threshold_mm};
      delta_q <= (in_action == ACT_TAKE_DELTA) ? d_take[15:0] : 16'd0;
      upd_q   <= status.upd_req;
      neg_q   <= d_rate[17];
      mag_q   <= d_abs[14:0];
    end
    if (cmd.prep) begin
      quo <= {20'd0, mag_q} * RATE_SCALE;
      rem <= '0;
    end
    if (cmd.div_step) begin
      if (!diff[21]) begin
        rem <= diff[19:0];
        quo <= {quo[33:0], 1'b1};
      end else begin
        rem <= rem_sh[19:0];
        quo <= {quo[33:0], 1'b0};
      end
    end
    if (cmd.mac) begin
      p_new <= a_new * raw;
      p_old <= a_old * filt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {7'd0, upd_q, filt, delta_q, flags_q};
    end
  end

endmodule

>>> rtl/yaw_rate_estimator_with_wall_flags.sv
// A rate update passes through prep, the 35-step restoring divider, the
// multiply and the filter sum; other items go straight to the output load,
// which waits for a free output register; only then is a new request taken,
// even while the previous result still waits on m_tready.
// Reset (rst, synchronous) clears the handshake, the filtered rate and both
// yaw references, and returns the configuration registers to their defaults.
module yaw_rate_estimator_with_wall_flags (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // yaw_cdeg[15:0], elapsed_us[35:16], left_mm[48:36], front_mm[61:49],
  // right_mm[74:62], zero pad[79:75]
  input  logic [yre_pkg::IN_DATA_W-1:0]   s_tdata,
  // action[1:0]
  input  logic [yre_pkg::IN_USER_W-1:0]   s_tuser,
  // Output stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // wall_left[0], wall_front[1], wall_right[2], yaw_delta_cdeg[18:3],
  // rate_cdeg_per_s[47:19], rate_updated[48], zero pad[55:49]
  output logic [yre_pkg::OUT_DATA_W-1:0]  m_tdata,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [yre_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [yre_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import yre_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  yre_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  yre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  yre_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .status  (status),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata)
  );

endmodule
